// ----- hdl/aprs_position_field_parser_macros.svh -----
// Assertion macros for the checker of the APRS position parser.
`ifndef APRS_POSITION_FIELD_PARSER_MACROS_SVH
`define APRS_POSITION_FIELD_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/apfp_pkg.sv -----
// Package with the constants of the APRS position parser.
package apfp_pkg;

  localparam int CALL_CHARS = 6;
  localparam int ALT_DIGITS = 6;

  localparam int CALL_SLOTS = 6;
  localparam int KEEP_INT   = (CALL_CHARS > CALL_SLOTS) ? CALL_SLOTS :
                              ((CALL_CHARS < 1) ? 1 : CALL_CHARS);
  localparam logic [2:0] KEEP_CHARS = 3'(KEEP_INT);

  function automatic longint alt_limit_f(input int digits);
    longint v;
    int     n;
    v = 1;
    n = (digits > 9) ? 9 : ((digits < 1) ? 1 : digits);
    for (int i = 0; i < n; i++) begin
      v = v * 10;
    end
    return v - 1;
  endfunction

  localparam longint ALT_LIMIT = alt_limit_f(ALT_DIGITS);
  localparam int     ALT_W     = $clog2(ALT_LIMIT + 1);
  localparam int     ALT_OUT_W = 20;

  localparam logic [20:0] LAT_MAX     = 21'd540000;
  localparam logic [20:0] LON_MAX     = 21'd1080000;
  localparam logic [13:0] MIN_INT_MAX = 14'd9999;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [1:0] {
    MODE_INT  = 2'd0,
    MODE_FRAC = 2'd1,
    MODE_STOP = 2'd2
  } num_mode_e;

  typedef struct packed {
    logic [9:0]  deg;
    logic        deg_stop;
    logic [13:0] mins;
    logic [6:0]  frac;
    logic [1:0]  dec;
    num_mode_e   mode;
  } num_t;

endpackage

// ----- hdl/aprs_position_field_parser.sv -----
// Top level of the APRS position parser: one byte per transaction, one result per sentence.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | char_byte_i, end_of_sentence_i
//  out     | output    | out_valid_o / out_stall_i | station_call_o ... altitude_seen_o
//
// Bytes are parsed in the cycle they are accepted: one per cycle while in_stall_o is low.
// The result of the final byte is registered and appears in the cycle after acceptance.
// A byte that does not end a sentence is accepted even while the output is stalled.
// A final byte is held off only while an earlier result still waits to be taken.
// Reset clears all parser state and the output valid flag.
module aprs_position_field_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_byte_i,
  input  logic               end_of_sentence_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [47:0]        station_call_o,
  output logic [2:0]         call_length_o,
  output logic               call_truncated_o,
  output logic signed [20:0] latitude_centiminutes_o,
  output logic signed [21:0] longitude_centiminutes_o,
  output logic               position_seen_o,
  output logic [19:0]        altitude_feet_o,
  output logic               altitude_seen_o
);

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_SKIP = 3'd1;
  localparam logic [2:0] PH_LAT  = 3'd2;
  localparam logic [2:0] PH_LON  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  localparam int AW = apfp_pkg::ALT_W;

  function automatic apfp_pkg::num_t clear_num();
    apfp_pkg::num_t n;
    n.deg      = '0;
    n.deg_stop = 1'b0;
    n.mins     = '0;
    n.frac     = '0;
    n.dec      = '0;
    n.mode     = apfp_pkg::MODE_INT;
    return n;
  endfunction

  function automatic apfp_pkg::num_t feed_degree(input apfp_pkg::num_t n,
                                                 input logic dig, input logic [3:0] d);
    apfp_pkg::num_t r;
    logic [13:0]    v;
    r = n;
    v = 14'(n.deg) * 14'd10 + 14'(d);
    if (!n.deg_stop) begin
      if (dig) begin
        r.deg = v[9:0];
      end else begin
        r.deg_stop = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic apfp_pkg::num_t feed_minutes(input apfp_pkg::num_t n,
                                                  input logic dig, input logic [3:0] d,
                                                  input logic is_dot);
    apfp_pkg::num_t r;
    logic [17:0]    v;
    logic [7:0]     f;
    r = n;
    v = 18'(n.mins) * 18'd10 + 18'(d);
    f = 8'(n.frac) * 8'd10 + 8'(d);
    if (n.mode != apfp_pkg::MODE_STOP) begin
      if (dig) begin
        if (n.mode == apfp_pkg::MODE_INT) begin
          r.mins = (v > 18'(apfp_pkg::MIN_INT_MAX)) ? apfp_pkg::MIN_INT_MAX : v[13:0];
        end else if (n.dec < 2'd2) begin
          r.frac = f[6:0];
          r.dec  = n.dec + 2'd1;
        end
      end else if (is_dot && (n.mode == apfp_pkg::MODE_INT)) begin
        r.mode = apfp_pkg::MODE_FRAC;
      end else begin
        r.mode = apfp_pkg::MODE_STOP;
      end
    end
    return r;
  endfunction

  logic [2:0]     phase_q, phase_d;
  logic [3:0]     fpos_q, fpos_d;
  logic [47:0]    call_q, call_d;
  logic [2:0]     ccnt_q, ccnt_d;
  logic           cdone_q, cdone_d;
  logic           ctrunc_q, ctrunc_d;
  apfp_pkg::num_t num_q, num_d, num_fed, num_src;
  logic [20:0]    lat_q, lat_d;
  logic [21:0]    lon_q, lon_d;
  logic           pos_q, pos_d;
  logic [AW-1:0]  alt_q, alt_d;
  logic           prev_a_q, prev_a_d;
  logic           prev_s_q, prev_s_d;
  logic           alt_act_q, alt_act_d;
  logic           alt_seen_q, alt_seen_d;

  logic           in_acc, out_load, out_valid_q;
  logic [7:0]     c;
  logic           dig, slash;
  logic [3:0]     dval;
  logic [AW+3:0]  alt_next;
  logic [6:0]     frac_v;
  logic [22:0]    total;
  logic [20:0]    lat_mag;
  logic [20:0]    lon_mag;
  logic [21:0]    lon_fin_w, lon_fin_p, lon_out;
  logic [20:0]    lat_fin;

  assign c     = char_byte_i;
  assign dig   = (c >= apfp_pkg::CH_ZERO) && (c <= apfp_pkg::CH_NINE);
  assign dval  = 4'(c - apfp_pkg::CH_ZERO);
  assign slash = (c == apfp_pkg::CH_SLASH);

  assign in_stall_o  = end_of_sentence_i && out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = in_acc && end_of_sentence_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    call_d   = call_q;
    ccnt_d   = ccnt_q;
    cdone_d  = cdone_q;
    ctrunc_d = ctrunc_q;
    if (!cdone_q) begin
      if (c == apfp_pkg::CH_DASH) begin
        cdone_d = 1'b1;
      end else if (ccnt_q < apfp_pkg::KEEP_CHARS) begin
        for (int i = 0; i < apfp_pkg::CALL_SLOTS; i++) begin
          if (ccnt_q == 3'(i)) begin
            call_d[8*(apfp_pkg::CALL_SLOTS-1-i) +: 8] = c;
          end
        end
        ccnt_d = ccnt_q + 3'd1;
      end else begin
        ctrunc_d = 1'b1;
      end
    end
  end

  assign alt_next = (AW+4)'(alt_q) * (AW+4)'(10) + (AW+4)'(dval);

  always_comb begin
    alt_d      = alt_q;
    alt_act_d  = alt_act_q;
    alt_seen_d = alt_seen_q;
    if (alt_act_q) begin
      if (dig) begin
        alt_d = (alt_next > (AW+4)'(apfp_pkg::ALT_LIMIT)) ? AW'(apfp_pkg::ALT_LIMIT)
                                                           : alt_next[AW-1:0];
      end else begin
        alt_act_d = 1'b0;
      end
    end else if ((c == apfp_pkg::CH_EQ) && prev_a_q && !alt_seen_q) begin
      alt_seen_d = 1'b1;
      alt_act_d  = 1'b1;
    end
    prev_a_d = (c == apfp_pkg::CH_A);
  end

  always_comb begin
    num_fed = num_q;
    case (phase_q)
      PH_LAT: begin
        if (fpos_q < 4'd2) begin
          num_fed = feed_degree(num_q, dig, dval);
        end else begin
          num_fed = feed_minutes(num_q, dig, dval, c == apfp_pkg::CH_DOT);
        end
      end
      PH_LON: begin
        if (fpos_q < 4'd3) begin
          num_fed = feed_degree(num_q, dig, dval);
        end else if (fpos_q < 4'd8) begin
          num_fed = feed_minutes(num_q, dig, dval, c == apfp_pkg::CH_DOT);
        end
      end
      default: begin
        num_fed = num_q;
      end
    endcase
  end

  assign num_src = (phase_q == PH_LAT) ? num_q : num_fed;
  assign frac_v  = (num_src.dec == 2'd1) ? 7'(num_src.frac * 7'd10) : num_src.frac;
  assign total   = 23'(num_src.deg) * 23'd6000 + 23'(num_src.mins) * 23'd100
                 + 23'(frac_v);
  assign lat_mag = (total > 23'(apfp_pkg::LAT_MAX)) ? apfp_pkg::LAT_MAX : total[20:0];
  assign lon_mag = (total > 23'(apfp_pkg::LON_MAX)) ? apfp_pkg::LON_MAX : total[20:0];
  assign lat_fin = prev_s_q ? (21'd0 - lat_mag) : lat_mag;
  assign lon_fin_p = {1'b0, lon_mag};
  assign lon_fin_w = (c == apfp_pkg::CH_W) ? (22'd0 - lon_fin_p) : lon_fin_p;

  always_comb begin
    phase_d  = phase_q;
    fpos_d   = fpos_q;
    num_d    = num_fed;
    lat_d    = lat_q;
    lon_d    = lon_q;
    pos_d    = pos_q;
    prev_s_d = prev_s_q;
    case (phase_q)
      PH_WAIT: begin
        if (c == apfp_pkg::CH_COLON) begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        phase_d  = PH_LAT;
        fpos_d   = '0;
        num_d    = clear_num();
        prev_s_d = 1'b0;
      end
      PH_LAT: begin
        if (slash) begin
          lat_d   = lat_fin;
          pos_d   = 1'b1;
          phase_d = PH_LON;
          fpos_d  = '0;
          num_d   = clear_num();
        end else begin
          if (fpos_q < 4'd15) begin
            fpos_d = fpos_q + 4'd1;
          end
          prev_s_d = (c == apfp_pkg::CH_S);
        end
      end
      PH_LON: begin
        if (fpos_q >= 4'd8) begin
          lon_d   = lon_fin_w;
          phase_d = PH_DONE;
        end else begin
          fpos_d = fpos_q + 4'd1;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_comb begin
    if ((phase_q == PH_LAT) && slash) begin
      lon_out = '0;
    end else if (phase_d == PH_LON) begin
      lon_out = lon_fin_p;
    end else begin
      lon_out = lon_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      fpos_q     <= '0;
      call_q     <= '0;
      ccnt_q     <= '0;
      cdone_q    <= 1'b0;
      ctrunc_q   <= 1'b0;
      num_q      <= clear_num();
      lat_q      <= '0;
      lon_q      <= '0;
      pos_q      <= 1'b0;
      alt_q      <= '0;
      prev_a_q   <= 1'b0;
      prev_s_q   <= 1'b0;
      alt_act_q  <= 1'b0;
      alt_seen_q <= 1'b0;
    end else if (in_acc) begin
      if (end_of_sentence_i) begin
        phase_q    <= PH_WAIT;
        fpos_q     <= '0;
        call_q     <= '0;
        ccnt_q     <= '0;
        cdone_q    <= 1'b0;
        ctrunc_q   <= 1'b0;
        num_q      <= clear_num();
        lat_q      <= '0;
        lon_q      <= '0;
        pos_q      <= 1'b0;
        alt_q      <= '0;
        prev_a_q   <= 1'b0;
        prev_s_q   <= 1'b0;
        alt_act_q  <= 1'b0;
        alt_seen_q <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        fpos_q     <= fpos_d;
        call_q     <= call_d;
        ccnt_q     <= ccnt_d;
        cdone_q    <= cdone_d;
        ctrunc_q   <= ctrunc_d;
        num_q      <= num_d;
        lat_q      <= lat_d;
        lon_q      <= lon_d;
        pos_q      <= pos_d;
        alt_q      <= alt_d;
        prev_a_q   <= prev_a_d;
        prev_s_q   <= prev_s_d;
        alt_act_q  <= alt_act_d;
        alt_seen_q <= alt_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      station_call_o           <= call_d;
      call_length_o            <= ccnt_d;
      call_truncated_o         <= ctrunc_d;
      latitude_centiminutes_o  <= pos_d ? $signed(lat_d) : 21'sd0;
      longitude_centiminutes_o <= pos_d ? $signed(lon_out) : 22'sd0;
      position_seen_o          <= pos_d;
      altitude_feet_o          <= apfp_pkg::ALT_OUT_W'(alt_d);
      altitude_seen_o          <= alt_seen_d;
    end
  end

endmodule

// ----- hdl/apfp_checker.sv -----
// Port-level checker for the APRS position parser, bound to the top level.
`include "aprs_position_field_parser_macros.svh"

module apfp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               end_of_sentence_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [47:0]        station_call_o,
  input logic [2:0]         call_length_o,
  input logic               call_truncated_o,
  input logic signed [20:0] latitude_centiminutes_o,
  input logic signed [21:0] longitude_centiminutes_o,
  input logic               position_seen_o,
  input logic [19:0]        altitude_feet_o,
  input logic               altitude_seen_o
);

  // A stalled result must stay presented with the same callsign.
  `APFP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(station_call_o), "stalled result changed")

  // Every accepted final byte produces a result in the next cycle.
  `APFP_ASSERT_NEXT(a_last_result, in_valid_i && !in_stall_o && end_of_sentence_i, out_valid_o, "final byte gave no result")

  `APFP_ASSERT_SAME(a_no_pos_zero, out_valid_o && !position_seen_o, (latitude_centiminutes_o == 21'sd0) && (longitude_centiminutes_o == 22'sd0), "position nonzero without marker")

  `APFP_ASSERT_SAME(a_no_alt_zero, out_valid_o && !altitude_seen_o, altitude_feet_o == 20'd0, "altitude nonzero without marker")

  `APFP_ASSERT_SAME(a_trunc_full, out_valid_o && call_truncated_o, call_length_o == apfp_pkg::KEEP_CHARS, "truncated callsign not full")

endmodule

bind aprs_position_field_parser apfp_checker u_apfp_checker (.*);
